// ===== rtl/srq_pkg.sv =====
// Shared types and codes for the strict-priority ready queue.
package srq_pkg;

   localparam int ACTION_W   = 2;
   localparam int PRIORITY_W = 4;
   localparam int TASK_ID_W  = 8;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 8;

   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TAKE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [PRIORITY_W-1:0] priority_req;
      logic [TASK_ID_W-1:0]  task_id;
   } req_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0] out_task_id;
      logic [STATUS_W-1:0]  status;
      logic [OCC_W-1:0]     occupancy;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request beat
      logic exec;      // run the latched request against the queues
   } cmd_type;

endpackage

// ===== rtl/strict_priority_ready_queue_unit.sv =====
// Strict-priority ready queue: LEVELS FIFOs of DEPTH task ids each, highest level
// served first. Each request beat (add, take, clear) returns exactly one response
// beat carrying the taken id, a status and the total occupancy. Each item is
// latched, then run against the id store (a single-port memory of LEVELS*DEPTH
// entries with registered read) while pointers and counts update; the response
// then shows and a new request is taken in the same cycle it is consumed, so
// one item is in flight; the next is latched as a result leaves. Priorities above
// LEVELS-1 are clamped; an add to a full level is dropped with a full status.
// Pointers and counts clear at reset; the id store needs no clearing.
module strict_priority_ready_queue_unit #(
   parameter int LEVELS  = 11,
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srq_pkg::rsp_type rsp_data
);

   srq_pkg::cmd_type cmd;

   srq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   srq_datapath #(
      .LEVELS  (LEVELS),
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/srq_ctrl.sv =====
// Sequencer for the ready queue: accept, execute, present result.
module srq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // a new beat may land in the same cycle the pending result is taken
   assign req_ready   = !reset &&
                        ((state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready));
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.exec    = (state_ff == ST_EXEC);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/srq_datapath.sv =====
// Queue datapath: id store, per-level pointers and counts, level select, result regs.
module srq_datapath #(
   parameter int LEVELS  = 11,
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  srq_pkg::cmd_type cmd,
   input  srq_pkg::req_type req_data,
   output srq_pkg::rsp_type rsp_data
);

   localparam int LVL_W     = $clog2(LEVELS);
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int MEM_DEPTH = LEVELS * DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
   localparam int STORE_W   = (ID_BITS < srq_pkg::TASK_ID_W) ? ID_BITS : srq_pkg::TASK_ID_W;

   srq_pkg::req_type item_ff;

   logic [PTR_W-1:0] head_ff  [LEVELS];
   logic [PTR_W-1:0] head_in  [LEVELS];
   logic [PTR_W-1:0] tail_ff  [LEVELS];
   logic [PTR_W-1:0] tail_in  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CNT_W-1:0] count_in [LEVELS];
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;

   logic [srq_pkg::STATUS_W-1:0] status_ff;
   logic [srq_pkg::STATUS_W-1:0] status_in;
   logic                         taken_ok_ff;
   logic                         taken_ok_in;

   logic [STORE_W-1:0] store_mem [MEM_DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   logic [LVL_W-1:0]  add_lvl;
   logic [LVL_W-1:0]  top_lvl;
   logic              found;
   logic              add_full;
   logic [LVL_W-1:0]  sel_lvl;
   logic [PTR_W-1:0]  sel_ptr;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic              mem_re;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (int'(p) >= DEPTH - 1) ? '0 : p + PTR_W'(1);
   endfunction

   // clamp requested priority to the top level
   always_comb begin
      if (int'(item_ff.priority_req) > LEVELS - 1) begin
         add_lvl = LVL_W'(LEVELS - 1);
      end else begin
         add_lvl = LVL_W'(item_ff.priority_req);
      end
   end

   assign add_full = (count_ff[add_lvl] == CNT_W'(DEPTH));

   // highest non-empty level; later hits override earlier ones
   always_comb begin
      found   = 1'b0;
      top_lvl = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (count_ff[l] != '0) begin
            found   = 1'b1;
            top_lvl = LVL_W'(l);
         end
      end
   end

   assign mem_addr = ADDR_W'(int'(sel_lvl) * DEPTH + int'(sel_ptr));

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      status_in   = status_ff;
      taken_ok_in = taken_ok_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      sel_lvl     = add_lvl;
      sel_ptr     = tail_ff[add_lvl];
      if (cmd.exec) begin
         status_in   = srq_pkg::STATUS_OK;
         taken_ok_in = 1'b0;
         case (item_ff.action)
            srq_pkg::ACT_ADD: begin
               if (add_full) begin
                  status_in = srq_pkg::STATUS_FULL;
               end else begin
                  mem_we            = 1'b1;
                  tail_in[add_lvl]  = next_ptr(tail_ff[add_lvl]);
                  count_in[add_lvl] = count_ff[add_lvl] + CNT_W'(1);
                  total_in          = total_ff + TOT_W'(1);
               end
            end
            srq_pkg::ACT_TAKE: begin
               sel_lvl = top_lvl;
               sel_ptr = head_ff[top_lvl];
               if (found) begin
                  mem_re            = 1'b1;
                  taken_ok_in       = 1'b1;
                  head_in[top_lvl]  = next_ptr(head_ff[top_lvl]);
                  count_in[top_lvl] = count_ff[top_lvl] - CNT_W'(1);
                  total_in          = total_ff - TOT_W'(1);
               end else begin
                  status_in = srq_pkg::STATUS_EMPTY;
               end
            end
            srq_pkg::ACT_CLEAR: begin
               for (int l = 0; l < LEVELS; l++) begin
                  head_in[l]  = '0;
                  tail_in[l]  = '0;
                  count_in[l] = '0;
               end
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         total_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      status_ff   <= status_in;
      taken_ok_ff <= taken_ok_in;
   end

   // single-port id store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= STORE_W'(item_ff.task_id);
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   assign rsp_data.out_task_id = taken_ok_ff ? srq_pkg::TASK_ID_W'(rd_data_ff) : '0;
   assign rsp_data.status      = status_ff;
   assign rsp_data.occupancy   = srq_pkg::OCC_W'(total_ff);

endmodule

// ===== rtl/srq_checker.sv =====
// Port-level checks for the ready queue, bound to the top level.
module srq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input srq_pkg::rsp_type rsp_data
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // accepted request yields its response once the execute state has passed
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
      else $error("response not presented after execute cycle");

   // one item in flight: no new request while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response pending");

   // empty take means nothing held and no id
   a_empty_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == srq_pkg::STATUS_EMPTY) |->
         (rsp_data.out_task_id == '0) && (rsp_data.occupancy == '0))
      else $error("empty status with nonzero id or occupancy");

   // dropped add returns no id
   a_full_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == srq_pkg::STATUS_FULL) |->
         (rsp_data.out_task_id == '0))
      else $error("full status with nonzero id");

endmodule

bind strict_priority_ready_queue_unit srq_checker u_srq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the strict-priority ready queue: directed plan, then random traffic.
module tb_top;
   import srq_pkg::*;

   localparam int LEVELS  = 11;
   localparam int DEPTH   = 16;
   localparam int ID_BITS = 8;

   // action code the block ignores; the package leaves it unnamed
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PHASE_COUNT     = 5;
   localparam int PHASE_ITEMS     = 300;
   localparam int BURST_ITEMS     = 30;
   localparam int HOLD_OFF_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   strict_priority_ready_queue_unit #(
      .LEVELS (LEVELS),
      .DEPTH  (DEPTH),
      .ID_BITS(ID_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // shadow copy of the level FIFOs; ints start at zero, matching reset
   logic [TASK_ID_W-1:0] shadow_ids [LEVELS][DEPTH];
   int                   shadow_head [LEVELS];
   int                   shadow_tail [LEVELS];
   int                   shadow_count [LEVELS];
   int                   shadow_total;

   rsp_type due_outcomes [$];
   int      mismatch_count;
   int      cycle_count;
   int      sender_idle_pct;
   int      receiver_stall_pct;
   int      hold_requests;
   int      holds_served;
   int      hold_left;

   typedef struct {
      req_type beat;
      int      reps;
      bit      known;
      rsp_type want;
   } plan_row_t;

   plan_row_t directed_plan [$];

   function automatic rsp_type apply_to_shadow_queue(input req_type beat);
      rsp_type outcome;
      int      lvl;
      bit      found;
      outcome = '0;
      outcome.status = STATUS_OK;
      found = 1'b0;
      lvl = (beat.priority_req > LEVELS - 1) ? LEVELS - 1 : int'(beat.priority_req);
      case (beat.action)
         ACT_ADD: begin
            if (shadow_count[lvl] >= DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               shadow_ids[lvl][shadow_tail[lvl]] = beat.task_id;
               shadow_tail[lvl] = (shadow_tail[lvl] + 1) % DEPTH;
               shadow_count[lvl]++;
               shadow_total++;
            end
         end
         ACT_TAKE: begin
            outcome.status = STATUS_EMPTY;
            for (int l = LEVELS - 1; l >= 0; l--) begin
               if (!found && shadow_count[l] > 0) begin
                  found = 1'b1;
                  outcome.out_task_id = shadow_ids[l][shadow_head[l]];
                  outcome.status = STATUS_OK;
                  shadow_head[l] = (shadow_head[l] + 1) % DEPTH;
                  shadow_count[l]--;
                  shadow_total--;
               end
            end
         end
         ACT_CLEAR: begin
            for (int l = 0; l < LEVELS; l++) begin
               shadow_head[l] = 0;
               shadow_tail[l] = 0;
               shadow_count[l] = 0;
            end
            shadow_total = 0;
         end
         default: begin
         end
      endcase
      outcome.occupancy = OCC_W'(shadow_total);
      return outcome;
   endfunction

   function automatic void plan_beat(input logic [ACTION_W-1:0] act,
                                     input logic [PRIORITY_W-1:0] pri,
                                     input logic [TASK_ID_W-1:0] id, input int reps);
      plan_row_t row;
      row.beat = '{action: act, priority_req: pri, task_id: id};
      row.reps = reps;
      row.known = 1'b0;
      row.want = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_known(input logic [ACTION_W-1:0] act,
                                      input logic [PRIORITY_W-1:0] pri,
                                      input logic [TASK_ID_W-1:0] id,
                                      input logic [TASK_ID_W-1:0] w_id,
                                      input logic [STATUS_W-1:0] w_status,
                                      input logic [OCC_W-1:0] w_occ);
      plan_row_t row;
      row.beat = '{action: act, priority_req: pri, task_id: id};
      row.reps = 1;
      row.known = 1'b1;
      row.want = '{out_task_id: w_id, status: w_status, occupancy: w_occ};
      directed_plan.push_back(row);
   endfunction

   // adds lean toward one focus level so levels actually fill up
   function automatic req_type random_beat(input int add_pct,
                                           input logic [PRIORITY_W-1:0] focus);
      req_type beat;
      int      roll;
      roll = $urandom_range(99);
      beat.task_id = TASK_ID_W'($urandom_range(255));
      beat.priority_req = ($urandom_range(1) == 0) ? focus : PRIORITY_W'($urandom_range(15));
      if (roll < 2) begin
         beat.action = ACT_CLEAR;
      end else if (roll < 4) begin
         beat.action = ACT_SPARE;
      end else if ($urandom_range(99) < add_pct) begin
         beat.action = ACT_ADD;
      end else begin
         beat.action = ACT_TAKE;
      end
      return beat;
   endfunction

   // entered and left at a falling edge; valid stays up between back-to-back beats
   task automatic drive_request(input req_type beat, input bit known, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_to_shadow_queue(beat);
      due_outcomes.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            $error("response beat with nothing expected: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = due_outcomes.pop_front();
            check_field("out_task_id", want.out_task_id, rsp_data.out_task_id);
            check_field("status", 8'(want.status), 8'(rsp_data.status));
            check_field("occupancy", want.occupancy, rsp_data.occupancy);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      req_type beat;
      int      add_pct;
      logic [PRIORITY_W-1:0] focus;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      plan_known(ACT_TAKE, 4'd0, 8'h00, 8'h00, STATUS_EMPTY, 8'd0);
      plan_known(ACT_SPARE, 4'd15, 8'hFF, 8'h00, STATUS_OK, 8'd0);
      plan_known(ACT_ADD, 4'd0, 8'h00, 8'h00, STATUS_OK, 8'd1);
      plan_known(ACT_ADD, 4'd15, 8'hFF, 8'h00, STATUS_OK, 8'd2);
      plan_beat(ACT_ADD, 4'd10, 8'hA5, 1);
      plan_beat(ACT_ADD, 4'd11, 8'h5A, 1);
      plan_beat(ACT_ADD, 4'd5, 8'h3C, 1);
      plan_known(ACT_TAKE, 4'd9, 8'h11, 8'hFF, STATUS_OK, 8'd4);
      plan_beat(ACT_TAKE, 4'd15, 8'hFF, 4);
      plan_known(ACT_TAKE, 4'd0, 8'h00, 8'h00, STATUS_EMPTY, 8'd0);
      plan_beat(ACT_ADD, 4'd7, 8'h81, 1);
      plan_known(ACT_SPARE, 4'd6, 8'hC3, 8'h00, STATUS_OK, 8'd1);
      plan_known(ACT_CLEAR, 4'd15, 8'hFF, 8'h00, STATUS_OK, 8'd0);
      plan_known(ACT_TAKE, 4'd3, 8'h42, 8'h00, STATUS_EMPTY, 8'd0);
      // fill one level, then overflow it; same for the clamped top level
      plan_beat(ACT_ADD, 4'd3, 8'h10, DEPTH);
      plan_known(ACT_ADD, 4'd3, 8'hEE, 8'h00, STATUS_FULL, 8'd16);
      plan_beat(ACT_ADD, 4'd12, 8'h40, DEPTH);
      plan_known(ACT_ADD, 4'd14, 8'h77, 8'h00, STATUS_FULL, 8'd32);
      plan_beat(ACT_TAKE, 4'd0, 8'h00, DEPTH + 1);
      plan_known(ACT_CLEAR, 4'd0, 8'h00, 8'h00, STATUS_OK, 8'd0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         for (int k = 0; k < directed_plan[i].reps; k++) begin
            beat = directed_plan[i].beat;
            beat.task_id = beat.task_id + TASK_ID_W'(k);
            drive_request(beat, directed_plan[i].known, directed_plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1:       begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
            3:       begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         endcase
         // last phase: receiver holds off while requests keep coming
         if (phase == PHASE_COUNT - 1) hold_requests++;
         for (int b = 0; b < PHASE_ITEMS / BURST_ITEMS; b++) begin
            case ($urandom_range(2))
               0:       add_pct = 80;
               1:       add_pct = 20;
               default: add_pct = 50;
            endcase
            focus = PRIORITY_W'($urandom_range(15));
            for (int n = 0; n < BURST_ITEMS; n++) begin
               drive_request(random_beat(add_pct, focus), 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/srq_pkg.sv
rtl/srq_ctrl.sv
rtl/srq_datapath.sv
rtl/strict_priority_ready_queue_unit.sv
rtl/srq_checker.sv
bench/tb_top.sv
